[src/sfe_pkg.sv]
// ----------------------------------------------------------------------------
// sfe_pkg
// Shared constants, event codes and controller/datapath interface types for
// the signal feature extractor.
// ----------------------------------------------------------------------------
`default_nettype none

package sfe_pkg;

    // Parameter defaults
    localparam int MAX_SAMPLES_DEF = 65536;
    localparam int SAMPLE_BITS_DEF = 24;

    // Field widths
    localparam int SMP_W  = 24;
    localparam int POS_W  = 16;
    localparam int TYPE_W = 4;
    localparam int CNT_W  = 17;
    localparam int SUM_W  = 41;
    localparam int SQS_W  = 64;
    localparam int MAG_W  = 40;
    localparam int ACC_W  = 80;
    localparam int DEN_W  = 34;

    // Event type codes
    localparam logic [TYPE_W-1:0] EV_RISE   = 4'd0;
    localparam logic [TYPE_W-1:0] EV_FALL   = 4'd1;
    localparam logic [TYPE_W-1:0] EV_RELMIN = 4'd2;
    localparam logic [TYPE_W-1:0] EV_RELMAX = 4'd3;
    localparam logic [TYPE_W-1:0] EV_ABSMIN = 4'd4;
    localparam logic [TYPE_W-1:0] EV_ABSMAX = 4'd5;
    localparam logic [TYPE_W-1:0] EV_DECAY  = 4'd6;
    localparam logic [TYPE_W-1:0] EV_MEAN   = 4'd7;
    localparam logic [TYPE_W-1:0] EV_DEV    = 4'd8;

    // Summary word selects, in emission order
    localparam logic [1:0] SUM_MEAN = 2'd0;
    localparam logic [1:0] SUM_DEV  = 2'd1;
    localparam logic [1:0] SUM_MIN  = 2'd2;
    localparam logic [1:0] SUM_MAX  = 2'd3;

    // e scaled by 2^60, split for two narrow multiplies
    localparam logic [31:0] E_LO = 32'h28AE_D2A6;
    localparam logic [29:0] E_HI = 30'h2B7E_1516;

    // Iteration counts of the end-of-run units
    localparam int DIV_STEPS  = 80;
    localparam int ACCA_STEPS = 17;
    localparam int ACCB_STEPS = 40;
    localparam int SQRT_STEPS = 32;
    localparam int ITER_W     = 7;

    typedef struct packed {
        logic       take;       // capture input word
        logic       mul1;       // low partial product and square
        logic       mul2;       // high partial product
        logic       eval;       // event flags and statistics update
        logic       emit_ev;    // send lowest pending event
        logic       div_init_mean;
        logic       div_init_dev;
        logic       div_step;
        logic       mean_save;
        logic       acc_init_a; // start count * square sum
        logic       acc_init_b; // start minus sum^2
        logic       acc_step;
        logic       acc_sub;
        logic       sqrt_init;
        logic       sqrt_step;
        logic       dev_save;
        logic       emit_sum;
        logic [1:0] sum_sel;
        logic       clear_run;
    } t_cmd;

    typedef struct packed {
        logic ev_pending;
        logic run_last;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

[src/sfe_dp.sv]
// ----------------------------------------------------------------------------
// sfe_dp
// Datapath: sample registers, decay multiplier, running statistics, serial
// multiply-accumulate, restoring divider, integer square root, output word.
// ----------------------------------------------------------------------------
`default_nettype none

module sfe_dp
    import sfe_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cmd              i_cmd,
    output t_status                o_st,
    input  wire logic [SMP_W-1:0]  i_sample,
    input  wire logic              i_last,
    input  wire logic              i_cfg_wen,
    input  wire logic              i_cfg_wdata,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [TYPE_W-1:0]      o_type,
    output logic [POS_W-1:0]       o_pos,
    output logic [SMP_W-1:0]       o_val,
    output logic                   o_last
);

    localparam logic [63:0] MAXV = 64'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);

    logic                    r_short;
    logic signed [SMP_W-1:0] r_x;
    logic                    r_last;
    logic [55:0]             r_plo;
    logic [53:0]             r_phi;
    logic [47:0]             r_sq;
    logic signed [SMP_W-1:0] r_first, r_prev, r_pprev, r_min, r_max, r_pv_snap;
    logic [POS_W-1:0]        r_min_idx, r_max_idx, r_pos_prev, r_pos_cur;
    logic [CNT_W-1:0]        r_count;
    logic signed [SUM_W-1:0] r_sum;
    logic [SQS_W-1:0]        r_sqsum;
    logic                    r_decay_seen;
    logic [4:0]              r_ev;
    logic [ACC_W-1:0]        r_acc, r_mc, r_dq;
    logic [MAG_W-1:0]        r_mp;
    logic [DEN_W:0]          r_rem;
    logic [DEN_W-1:0]        r_den;
    logic [63:0]             r_sv, r_sr, r_sb;
    logic signed [SMP_W-1:0] r_mean, r_dev;
    logic                    r_out_valid;
    logic [TYPE_W-1:0]       r_out_type;
    logic [POS_W-1:0]        r_out_pos;
    logic [SMP_W-1:0]        r_out_val;
    logic                    r_out_last;

    // Input sign extension from SAMPLE_BITS
    logic signed [SAMPLE_BITS-1:0] x_narrow;
    logic signed [SMP_W-1:0]       x_in;
    assign x_narrow = i_sample[SAMPLE_BITS-1:0];
    assign x_in     = SMP_W'(x_narrow);

    // Magnitudes
    logic [SMP_W-1:0]        a_mag, b_mag;
    logic signed [SMP_W-1:0] b_val;
    logic signed [47:0]      sq_s;
    logic [MAG_W-1:0]        sum_mag;
    assign a_mag   = r_x[SMP_W-1] ? SMP_W'(-r_x) : r_x;
    assign b_val   = (r_count == '0) ? r_x : r_first;
    assign b_mag   = b_val[SMP_W-1] ? SMP_W'(-b_val) : b_val;
    assign sq_s    = 48'(r_x) * 48'(r_x);
    assign sum_mag = r_sum[SUM_W-1] ? MAG_W'(-r_sum) : MAG_W'(r_sum);

    // Decay compare: |x| * e against |first| * 2^60
    logic [87:0] prod, bq;
    logic        p_lt, p_gt, decays;
    assign prod = (88'(r_phi) << 32) + 88'(r_plo);
    assign bq   = 88'(b_mag) << 60;
    assign p_lt = prod < bq;
    assign p_gt = prod > bq;
    always_comb begin
        priority if (!r_x[SMP_W-1] && !b_val[SMP_W-1]) decays = p_lt;
        else if (!r_x[SMP_W-1])                        decays = 1'b0;
        else if (!b_val[SMP_W-1])                      decays = 1'b1;
        else                                           decays = p_gt;
    end

    // Event flags for the current word
    logic       active, allow;
    logic [4:0] ev_new;
    assign active = r_count < CNT_W'(MAX_SAMPLES);
    assign allow  = active && !r_short;
    always_comb begin
        ev_new[0] = allow && (r_count >= 17'd2) && (r_pprev >= r_prev) && (r_prev <= r_x);
        ev_new[1] = allow && (r_count >= 17'd2) && (r_pprev <= r_prev) && (r_prev >= r_x);
        ev_new[2] = allow && (r_count >= 17'd1) && (r_prev >= 0) && (r_x < 0);
        ev_new[3] = allow && (r_count >= 17'd1) && (r_prev <= 0) && (r_x > 0);
        ev_new[4] = active && !r_decay_seen && decays;
    end

    // Pick lowest pending event
    logic [TYPE_W-1:0] ev_type;
    logic [POS_W-1:0]  ev_pos;
    logic [SMP_W-1:0]  ev_val;
    logic [4:0]        ev_clr;
    always_comb begin
        ev_pos = r_pos_prev;
        ev_val = r_pv_snap;
        priority if (r_ev[0]) begin
            ev_type = EV_RELMIN; ev_clr = 5'b00001;
        end else if (r_ev[1]) begin
            ev_type = EV_RELMAX; ev_clr = 5'b00010;
        end else if (r_ev[2]) begin
            ev_type = EV_FALL;   ev_clr = 5'b00100;
        end else if (r_ev[3]) begin
            ev_type = EV_RISE;   ev_clr = 5'b01000;
        end else begin
            ev_type = EV_DECAY;  ev_clr = 5'b10000;
            ev_pos  = r_pos_cur;
            ev_val  = r_x;
        end
    end

    // Summary word select
    logic [TYPE_W-1:0] sm_type;
    logic [POS_W-1:0]  sm_pos;
    logic [SMP_W-1:0]  sm_val;
    always_comb begin
        unique case (i_cmd.sum_sel)
            SUM_MEAN: begin sm_type = EV_MEAN;   sm_pos = '0;        sm_val = r_mean; end
            SUM_DEV:  begin sm_type = EV_DEV;    sm_pos = '0;        sm_val = r_dev;  end
            SUM_MIN:  begin sm_type = EV_ABSMIN; sm_pos = r_min_idx; sm_val = r_min;  end
            default:  begin sm_type = EV_ABSMAX; sm_pos = r_max_idx; sm_val = r_max;  end
        endcase
    end

    // Divider, sqrt step logic
    logic [DEN_W:0] div_t;
    logic           div_ge;
    logic [63:0]    sq_rb;
    logic [63:0]    dev_c;
    assign div_t  = {r_rem[DEN_W-1:0], r_dq[ACC_W-1]};
    assign div_ge = div_t >= {1'b0, r_den};
    assign sq_rb  = r_sr + r_sb;
    assign dev_c  = (r_sr > MAXV) ? MAXV : r_sr;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short      <= 1'b0;
            r_count      <= '0;
            r_sum        <= '0;
            r_sqsum      <= '0;
            r_decay_seen <= 1'b0;
            r_ev         <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_wen) r_short <= i_cfg_wdata;
            if (i_cmd.eval) begin
                r_ev <= ev_new;
                if (active) begin
                    r_count      <= r_count + 1'b1;
                    r_sum        <= r_sum + SUM_W'(r_x);
                    r_sqsum      <= r_sqsum + SQS_W'(r_sq);
                    r_decay_seen <= r_decay_seen | ev_new[4];
                end
            end else if (i_cmd.emit_ev) begin
                r_ev <= r_ev & ~ev_clr;
            end
            if (i_cmd.clear_run) begin
                r_count      <= '0;
                r_sum        <= '0;
                r_sqsum      <= '0;
                r_decay_seen <= 1'b0;
            end
            if (i_cmd.emit_ev || i_cmd.emit_sum) r_out_valid <= 1'b1;
            else if (i_ready)                    r_out_valid <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_x    <= x_in;
            r_last <= i_last;
        end
        if (i_cmd.mul1) begin
            r_plo <= 56'(a_mag) * 56'(E_LO);
            r_sq  <= $unsigned(sq_s);
        end
        if (i_cmd.mul2) r_phi <= 54'(a_mag) * 54'(E_HI);
        if (i_cmd.eval) begin
            r_pv_snap  <= r_prev;
            r_pos_prev <= POS_W'(r_count - 1'b1);
            r_pos_cur  <= r_count[POS_W-1:0];
            if (active) begin
                r_pprev <= r_prev;
                r_prev  <= r_x;
                if (r_count == '0) begin
                    r_first   <= r_x;
                    r_min     <= r_x;
                    r_max     <= r_x;
                    r_min_idx <= '0;
                    r_max_idx <= '0;
                end else begin
                    if (r_x < r_min) begin
                        r_min <= r_x; r_min_idx <= r_count[POS_W-1:0];
                    end
                    if (r_x > r_max) begin
                        r_max <= r_x; r_max_idx <= r_count[POS_W-1:0];
                    end
                end
            end
        end
        // divider
        if (i_cmd.div_init_mean) begin
            r_dq  <= (ACC_W'(sum_mag) << 1) + ACC_W'(r_count);
            r_den <= DEN_W'({r_count, 1'b0});
            r_rem <= '0;
        end else if (i_cmd.div_init_dev) begin
            r_dq  <= r_acc;
            r_den <= DEN_W'(r_count) * DEN_W'(r_count - 1'b1);
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= div_ge ? div_t - {1'b0, r_den} : div_t;
            r_dq  <= {r_dq[ACC_W-2:0], div_ge};
        end
        if (i_cmd.mean_save)
            r_mean <= r_sum[SUM_W-1] ? SMP_W'(-r_dq[SMP_W-1:0]) : r_dq[SMP_W-1:0];
        // serial multiply-accumulate of count*sqsum - sum^2
        if (i_cmd.acc_init_a) begin
            r_acc <= '0;
            r_mc  <= ACC_W'(r_sqsum);
            r_mp  <= MAG_W'(r_count);
        end else if (i_cmd.acc_init_b) begin
            r_mc <= ACC_W'(sum_mag);
            r_mp <= sum_mag;
        end else if (i_cmd.acc_step) begin
            if (r_mp[0]) r_acc <= i_cmd.acc_sub ? r_acc - r_mc : r_acc + r_mc;
            r_mc <= r_mc << 1;
            r_mp <= r_mp >> 1;
        end
        // square root, two bits per step
        if (i_cmd.sqrt_init) begin
            r_sv <= r_dq[63:0];
            r_sr <= '0;
            r_sb <= 64'd1 << 62;
        end else if (i_cmd.sqrt_step) begin
            if (r_sv >= sq_rb) begin
                r_sv <= r_sv - sq_rb;
                r_sr <= (r_sr >> 1) + r_sb;
            end else begin
                r_sr <= r_sr >> 1;
            end
            r_sb <= r_sb >> 2;
        end
        if (i_cmd.dev_save)
            r_dev <= (r_count < 17'd2) ? '0 : dev_c[SMP_W-1:0];
        // output word
        if (i_cmd.emit_ev) begin
            r_out_type <= ev_type;
            r_out_pos  <= ev_pos;
            r_out_val  <= ev_val;
            r_out_last <= 1'b0;
        end else if (i_cmd.emit_sum) begin
            r_out_type <= sm_type;
            r_out_pos  <= sm_pos;
            r_out_val  <= sm_val;
            r_out_last <= (i_cmd.sum_sel == SUM_MAX);
        end
    end

    assign o_st.ev_pending = |r_ev;
    assign o_st.run_last   = r_last;
    assign o_st.out_free   = !r_out_valid || i_ready;

    assign o_valid = r_out_valid;
    assign o_type  = r_out_type;
    assign o_pos   = r_out_pos;
    assign o_val   = r_out_val;
    assign o_last  = r_out_last;

    // Checks
    a_clear_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clear_run |=> (r_count == '0) && !r_decay_seen)
        else $error("run state not cleared");
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_SAMPLES))
        else $error("sample count beyond limit");
    a_decay_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.eval && r_decay_seen) |=> !r_ev[4])
        else $error("second decay event in one run");

endmodule

`default_nettype wire

[src/sfe_ctrl.sv]
// ----------------------------------------------------------------------------
// sfe_ctrl
// Controller: sequences per-sample evaluation, event emission and the
// end-of-run mean, variance and square root iterations.
// ----------------------------------------------------------------------------
`default_nettype none

module sfe_ctrl
    import sfe_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_tvalid,
    output logic         o_tready,
    input  wire t_status i_st,
    output t_cmd         o_cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MUL1  = 4'd1;
    localparam logic [3:0] S_MUL2  = 4'd2;
    localparam logic [3:0] S_EVAL  = 4'd3;
    localparam logic [3:0] S_EMIT  = 4'd4;
    localparam logic [3:0] S_DIVM  = 4'd5;
    localparam logic [3:0] S_MEANW = 4'd6;
    localparam logic [3:0] S_ACCA  = 4'd7;
    localparam logic [3:0] S_ACCBI = 4'd8;
    localparam logic [3:0] S_ACCB  = 4'd9;
    localparam logic [3:0] S_DIVD  = 4'd10;
    localparam logic [3:0] S_SQI   = 4'd11;
    localparam logic [3:0] S_SQ    = 4'd12;
    localparam logic [3:0] S_DEVW  = 4'd13;
    localparam logic [3:0] S_SUM   = 4'd14;

    logic [3:0]        r_state, n_state;
    logic [ITER_W-1:0] r_cnt, n_cnt;
    logic [1:0]        r_sel, n_sel;

    // Next state and commands
    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_sel    = r_sel;
        o_cmd    = '0;
        o_cmd.sum_sel = r_sel;
        o_tready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_tready = 1'b1;
                if (i_tvalid) begin
                    o_cmd.take = 1'b1;
                    n_state    = S_MUL1;
                end
            end
            S_MUL1: begin o_cmd.mul1 = 1'b1; n_state = S_MUL2; end
            S_MUL2: begin o_cmd.mul2 = 1'b1; n_state = S_EVAL; end
            S_EVAL: begin o_cmd.eval = 1'b1; n_state = S_EMIT; end
            S_EMIT: begin
                if (i_st.ev_pending) begin
                    o_cmd.emit_ev = i_st.out_free;
                end else if (i_st.run_last) begin
                    o_cmd.div_init_mean = 1'b1;
                    n_cnt   = '0;
                    n_state = S_DIVM;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_DIVM: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == ITER_W'(DIV_STEPS - 1)) n_state = S_MEANW;
            end
            S_MEANW: begin
                o_cmd.mean_save  = 1'b1;
                o_cmd.acc_init_a = 1'b1;
                n_cnt   = '0;
                n_state = S_ACCA;
            end
            S_ACCA: begin
                o_cmd.acc_step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == ITER_W'(ACCA_STEPS - 1)) n_state = S_ACCBI;
            end
            S_ACCBI: begin
                o_cmd.acc_init_b = 1'b1;
                n_cnt   = '0;
                n_state = S_ACCB;
            end
            S_ACCB: begin
                o_cmd.acc_step = 1'b1;
                o_cmd.acc_sub  = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == ITER_W'(ACCB_STEPS - 1)) begin
                    n_state = S_DIVD;
                    n_cnt   = '0;
                end
            end
            S_DIVD: begin
                // first cycle loads the dividend, the rest iterate
                if (r_cnt == '0) o_cmd.div_init_dev = 1'b1;
                else             o_cmd.div_step     = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == ITER_W'(DIV_STEPS)) n_state = S_SQI;
            end
            S_SQI: begin
                o_cmd.sqrt_init = 1'b1;
                n_cnt   = '0;
                n_state = S_SQ;
            end
            S_SQ: begin
                o_cmd.sqrt_step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == ITER_W'(SQRT_STEPS - 1)) n_state = S_DEVW;
            end
            S_DEVW: begin
                o_cmd.dev_save = 1'b1;
                n_sel   = SUM_MEAN;
                n_state = S_SUM;
            end
            S_SUM: begin
                if (i_st.out_free) begin
                    o_cmd.emit_sum = 1'b1;
                    n_sel = r_sel + 1'b1;
                    if (r_sel == SUM_MAX) begin
                        o_cmd.clear_run = 1'b1;
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_sel   <= SUM_MEAN;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_sel   <= n_sel;
        end
    end

    // Checks
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit_ev || o_cmd.emit_sum) |-> i_st.out_free)
        else $error("output word overwritten while stalled");
    a_take_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_tvalid && o_tready) |=> (r_state == S_MUL1))
        else $error("accepted word not processed");
    a_div_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIVM) |-> (r_cnt < ITER_W'(DIV_STEPS)))
        else $error("divider ran past its step count");

endmodule

`default_nettype wire

[src/signal_feature_extractor.sv]
// ----------------------------------------------------------------------------
// signal_feature_extractor
// Peak, zero crossing, decay and run statistics detector over sample runs.
// ----------------------------------------------------------------------------
// Usage:
//  Input stream s_axis: tdata carries one signed sample, tlast closes a run.
//  Output stream m_axis: tuser is the event type, tdata holds position and
//  value, tlast marks the absolute maximum that ends a run's results.
//  short_display is written through i_cfg_wen / i_cfg_wdata while idle.
//  The user writes short_display only while idle; the block never checks.
// Operation:
//  A sample is taken, passes the low and high multiply steps and the
//  evaluation step, then each pending event word is emitted in turn.
//  After a word with tlast and its event words the summary divides for the
//  mean, accumulates count * square sum minus sum^2, divides for the
//  variance, takes the square root, then emits four words (mean, deviation,
//  min, max). Results sit in an output register; a stalled receiver holds
//  the block in its emit step and s_axis_tready stays low until words drain.
//  s_axis_tready is high only while idle, so samples are taken one at a time.
//  Reset clears the run and short_display; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module signal_feature_extractor
    import sfe_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // [23:0] sample
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // [15:0] position, [39:16] value
    output logic [3:0]       m_axis_tuser,   // [3:0] event_type
    output logic             m_axis_tlast,
    input  wire logic        i_cfg_wen,
    input  wire logic        i_cfg_wdata
);

    t_cmd              cmd;
    t_status           st;
    logic [POS_W-1:0]  out_pos;
    logic [SMP_W-1:0]  out_val;

    sfe_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tvalid (s_axis_tvalid),
        .o_tready (s_axis_tready),
        .i_st     (st),
        .o_cmd    (cmd)
    );

    sfe_dp #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_st        (st),
        .i_sample    (s_axis_tdata),
        .i_last      (s_axis_tlast),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_wdata (i_cfg_wdata),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_type      (m_axis_tuser),
        .o_pos       (out_pos),
        .o_val       (out_val),
        .o_last      (m_axis_tlast)
    );

    assign m_axis_tdata = {out_val, out_pos};

endmodule

`default_nettype wire
